// ----- sv/pds_pkg.sv -----
`default_nettype none

package pds_pkg;

  // input op codes
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_INIT   = 3'd1;
  localparam logic [2:0] OP_OTHER  = 3'd2;
  localparam logic [2:0] OP_RMC_T  = 3'd3;
  localparam logic [2:0] OP_RMC_P  = 3'd4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_GIVEUP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESYNC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_D = 3'd4;

  // configuration reset values
  localparam logic [15:0] GIVEUP_RST = 16'd600;
  localparam logic [23:0] STEP_RST   = 24'd86400;
  localparam logic [15:0] BUDGET_RST = 16'd60;
  localparam logic [15:0] RESYNC_RST = 16'd60;
  localparam logic [15:0] INIT_D_RST = 16'd900;

  // port field width for times
  localparam int PORT_TIME_W = 32;

  typedef struct packed {
    logic busy;
    logic done;
  } pds_div_stat_t;

  typedef struct packed {
    logic        power_on;
    logic [31:0] clock_out;
    logic [31:0] wake_time;
    logic [31:0] last_start_time;
    logic [31:0] lock_time;
    logic        position_set;
    logic [15:0] last_active;
    logic [31:0] total_active;
    logic [15:0] start_count;
    logic [15:0] timeout_count;
    logic [31:0] message_count;
  } pds_result_t;

endpackage

`default_nettype wire

// ----- sv/pds_if.sv -----
`default_nettype none

interface pds_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] clock_time;
  logic [31:0] gps_time;
  logic        start_enabled;

  modport source (output valid, op, clock_time, gps_time, start_enabled, input ready);
  modport sink   (input valid, op, clock_time, gps_time, start_enabled, output ready);
  modport mon    (input valid, ready, op, clock_time, gps_time, start_enabled);
endinterface

interface pds_out_if;
  logic        valid;
  logic        ready;
  logic        power_on;
  logic [31:0] clock_out;
  logic [31:0] wake_time;
  logic [31:0] last_start_time;
  logic [31:0] lock_time;
  logic        position_set;
  logic [15:0] last_active;
  logic [31:0] total_active;
  logic [15:0] start_count;
  logic [15:0] timeout_count;
  logic [31:0] message_count;

  modport source (output valid, power_on, clock_out, wake_time, last_start_time, lock_time,
                  position_set, last_active, total_active, start_count, timeout_count,
                  message_count, input ready);
  modport sink   (input valid, power_on, clock_out, wake_time, last_start_time, lock_time,
                  position_set, last_active, total_active, start_count, timeout_count,
                  message_count, output ready);
  modport mon    (input valid, ready, power_on, clock_out, wake_time, last_start_time,
                  lock_time, position_set, last_active, total_active, start_count,
                  timeout_count, message_count);
endinterface

`default_nettype wire

// ----- sv/pds_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module pds_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [15:0]           dividend,
  input  wire logic [15:0]           divisor,
  output pds_pkg::pds_div_stat_t     stat,
  output logic [15:0]                quotient
);
  import pds_pkg::*;

  logic [4:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] quo_r, quo_nxt;
  logic [15:0] dvs_r, dvs_nxt;
  logic [16:0] shl;
  logic [16:0] diff;

  assign shl  = {rem_r[15:0], quo_r[15]};
  assign diff = shl - {1'b0, dvs_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = 5'd16;
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != 5'd0) begin
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
      if (shl >= {1'b0, dvs_r}) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[14:0], 1'b1};
      end else begin
        rem_nxt = shl;
        quo_nxt = {quo_r[14:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = (cnt_r != 5'd0);
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// ----- sv/gps_power_duty_scheduler.sv -----
// Receiver power duty scheduler, one item in flight at a time.
// When a power-off after more than one start sizes the next wait, the item goes
// through the divider, then one multiply, then one add, before its result is registered.
// A new item is not taken until the previous item's result is in the output register.
// Reset (rst_n low, synchronous): power off, all state and counters zero,
// configuration registers back to their defaults, no result pending.
`default_nettype none

module gps_power_duty_scheduler #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pds_in_if.sink                             in_ch,
  pds_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [pds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pds_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pds_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int PROD_W = 41;   // 17-bit multiple times 24-bit step

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r, state_nxt;

  // configuration
  logic [15:0] giveup_r, budget_r, resync_r, init_d_r;
  logic [23:0] step_r;

  // scheduler state
  logic          powered_r, powered_nxt;
  logic [TB-1:0] wake_r, wake_nxt;
  logic [TB-1:0] start_r, start_nxt;
  logic [TB-1:0] lock_r, lock_nxt;
  logic [15:0]   active_r, active_nxt;
  logic [31:0]   total_r, total_nxt;
  logic [15:0]   starts_r, starts_nxt;
  logic [15:0]   timeouts_r, timeouts_nxt;
  logic [31:0]   msgs_r, msgs_nxt;

  // latched item
  logic [2:0]    op_r;
  logic [TB-1:0] clk_r, g_r;
  logic          en_r;
  logic [31:0]   clkout_r, clkout_nxt;

  // power-off time and product for the divide path
  logic [TB-1:0]     pdt_r, pdt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  pds_result_t res_r, res_nxt;

  // divider for sizing the next wait
  logic          div_start;
  logic [15:0]   div_dvs;
  logic [15:0]   div_q;
  pds_div_stat_t div_stat;

  assign div_dvs = (budget_r == 16'd0) ? 16'd1 : budget_r;

  pds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (active_nxt),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_q)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    logic          pd_v;
    logic [TB-1:0] t_v;
    logic [TB-1:0] w_v;
    logic [TB-1:0] lim_v;
    logic [TB-1:0] act_t;
    logic [31:0]   delta_v;
    logic [16:0]   mult_v;

    state_nxt    = state_r;
    powered_nxt  = powered_r;
    wake_nxt     = wake_r;
    start_nxt    = start_r;
    lock_nxt     = lock_r;
    active_nxt   = active_r;
    total_nxt    = total_r;
    starts_nxt   = starts_r;
    timeouts_nxt = timeouts_r;
    msgs_nxt     = msgs_r;
    clkout_nxt   = clkout_r;
    pdt_nxt      = pdt_r;
    prod_nxt     = prod_r;
    div_start    = 1'b0;
    pd_v         = 1'b0;
    t_v          = clk_r;
    w_v          = wake_r;
    lim_v        = wake_r + TB'(giveup_r);
    act_t        = '0;
    delta_v      = (g_r[31:0] > clk_r[31:0]) ? g_r[31:0] - clk_r[31:0]
                                             : clk_r[31:0] - g_r[31:0];
    mult_v       = {1'b0, div_q} + 17'd1;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        clkout_nxt = clk_r[31:0];
        state_nxt  = S_DONE;
        case (op_r)
          OP_TICK: begin
            if (powered_r) begin
              if (clk_r > lim_v) begin
                timeouts_nxt = timeouts_r + 16'd1;
                if (lock_r != '0) begin
                  pd_v = 1'b1;
                end else begin
                  // no fix yet: close the accounting and restart the session
                  act_t      = clk_r - wake_r;
                  active_nxt = act_t[15:0];
                  total_nxt  = total_r + {16'd0, act_t[15:0]};
                  wake_nxt   = clk_r;
                end
              end
            end else if (clk_r >= wake_r) begin
              powered_nxt = 1'b1;
              wake_nxt    = clk_r;
              start_nxt   = clk_r;
              starts_nxt  = starts_r + 16'd1;
            end
          end
          OP_INIT: begin
            lock_nxt    = '0;
            powered_nxt = 1'b0;
            if (en_r) begin
              powered_nxt = 1'b1;
              wake_nxt    = clk_r;
              start_nxt   = clk_r;
              starts_nxt  = starts_r + 16'd1;
            end else begin
              wake_nxt = clk_r + TB'(init_d_r);
            end
          end
          OP_OTHER, OP_RMC_T, OP_RMC_P: begin
            if (powered_r) begin
              msgs_nxt = msgs_r + 32'd1;
              if (op_r != OP_OTHER) begin
                clkout_nxt = g_r[31:0];
                if (delta_v > {16'd0, resync_r}) begin
                  wake_nxt = g_r;
                  w_v      = g_r;
                end
                if (op_r == OP_RMC_P) begin
                  lock_nxt = g_r;
                  t_v      = g_r;
                  pd_v     = 1'b1;
                end
              end
            end
          end
          default: begin
          end
        endcase

        // power-off with session accounting
        if (pd_v) begin
          act_t       = t_v - w_v;
          active_nxt  = act_t[15:0];
          total_nxt   = total_r + {16'd0, act_t[15:0]};
          powered_nxt = 1'b0;
          if (starts_r <= 16'd1) begin
            wake_nxt = t_v + TB'(step_r);
          end else begin
            div_start = 1'b1;
            pdt_nxt   = t_v;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(mult_v) * PROD_W'(step_r);
        state_nxt = S_WB;
      end
      S_WB: begin
        wake_nxt  = TB'(64'(pdt_r) + 64'(prod_r));
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register: loaded when the sequencer finishes and the slot is free
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
      out_valid_nxt         = 1'b1;
      res_nxt.power_on        = powered_r;
      res_nxt.clock_out       = clkout_r;
      res_nxt.wake_time       = wake_r[31:0];
      res_nxt.last_start_time = start_r[31:0];
      res_nxt.lock_time       = lock_r[31:0];
      res_nxt.position_set    = (lock_r != '0);
      res_nxt.last_active     = active_r;
      res_nxt.total_active    = total_r;
      res_nxt.start_count     = starts_r;
      res_nxt.timeout_count   = timeouts_r;
      res_nxt.message_count   = msgs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      giveup_r    <= GIVEUP_RST;
      step_r      <= STEP_RST;
      budget_r    <= BUDGET_RST;
      resync_r    <= RESYNC_RST;
      init_d_r    <= INIT_D_RST;
      powered_r   <= 1'b0;
      wake_r      <= '0;
      start_r     <= '0;
      lock_r      <= '0;
      active_r    <= '0;
      total_r     <= '0;
      starts_r    <= '0;
      timeouts_r  <= '0;
      msgs_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      powered_r   <= powered_nxt;
      wake_r      <= wake_nxt;
      start_r     <= start_nxt;
      lock_r      <= lock_nxt;
      active_r    <= active_nxt;
      total_r     <= total_nxt;
      starts_r    <= starts_nxt;
      timeouts_r  <= timeouts_nxt;
      msgs_r      <= msgs_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GIVEUP: giveup_r <= cfg_wdata[15:0];
          CFG_STEP:   step_r   <= cfg_wdata;
          CFG_BUDGET: budget_r <= cfg_wdata[15:0];
          CFG_RESYNC: resync_r <= cfg_wdata[15:0];
          CFG_INIT_D: init_d_r <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
    end
    // item capture and datapath, no reset needed
    if (state_r == S_IDLE && in_ch.valid) begin
      op_r  <= in_ch.op;
      clk_r <= TB'(in_ch.clock_time);
      g_r   <= TB'(in_ch.gps_time);
      en_r  <= in_ch.start_enabled;
    end
    clkout_r <= clkout_nxt;
    pdt_r    <= pdt_nxt;
    prod_r   <= prod_nxt;
    res_r    <= res_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.power_on        = res_r.power_on;
  assign out_ch.clock_out       = res_r.clock_out;
  assign out_ch.wake_time       = res_r.wake_time;
  assign out_ch.last_start_time = res_r.last_start_time;
  assign out_ch.lock_time       = res_r.lock_time;
  assign out_ch.position_set    = res_r.position_set;
  assign out_ch.last_active     = res_r.last_active;
  assign out_ch.total_active    = res_r.total_active;
  assign out_ch.start_count     = res_r.start_count;
  assign out_ch.timeout_count   = res_r.timeout_count;
  assign out_ch.message_count   = res_r.message_count;

endmodule

`default_nettype wire

// ----- sv/pds_checker.sv -----
`default_nettype none

module pds_checker (
  input wire logic  clk,
  input wire logic  rst_n,
  pds_in_if.sink    in_ch,
  pds_out_if.source out_ch
);
  import pds_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.wake_time)
      && $stable(out_ch.message_count))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while busy");

  // lock flag follows lock time
  a_pos_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.position_set == (out_ch.lock_time != 32'd0)))
    else $error("position_set disagrees with lock_time");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

endmodule

bind gps_power_duty_scheduler pds_checker u_pds_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

`default_nettype wire
